/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions, held off while reset is asserted
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clk, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tmbs_pkg.sv */
// ---------------------------------------------------------------------------
// tmbs_pkg
// shared types, widths, codes and the column mux table of the matrix scanner
// ---------------------------------------------------------------------------
`default_nettype none

package tmbs_pkg;

  localparam int ROWS_DEF    = 16;
  localparam int COLUMNS_DEF = 16;

  localparam int OP_W     = 2;
  localparam int SAMPLE_W = 8;
  localparam int PIXEL_W  = 7;
  localparam int ROW_W    = 4;
  localparam int PAIR_W   = 3;
  localparam int IDX_W    = 8;
  localparam int DRIVE_W  = 16;
  localparam int MUX_W    = 8;
  localparam int PASS_W   = 8;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 8;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [CFG_AW-1:0]   cfg_idx_t;
  typedef logic [PIXEL_W-1:0]  pixel_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  localparam op_t OP_START_CAL  = 2'd0;
  localparam op_t OP_START_SCAN = 2'd1;
  localparam op_t OP_SAMPLE     = 2'd2;

  localparam cfg_idx_t REG_CAL_PASSES = 2'd0;
  localparam cfg_idx_t REG_MIRROR_X   = 2'd1;
  localparam cfg_idx_t REG_MIRROR_Y   = 2'd2;

  localparam pixel_t            PIXEL_MAX    = 7'd127;
  localparam logic [PASS_W-1:0] PASSES_RESET = 8'd10;

  localparam logic [DRIVE_W-1:0] DRIVE_FIRST_UP   = 16'h0001;
  localparam logic [DRIVE_W-1:0] DRIVE_FIRST_DOWN = 16'h8000;

  // dual mux byte per column pair; the mirrored table is the same one reversed
  function automatic logic [MUX_W-1:0] mux_lookup(input logic [PAIR_W-1:0] pair,
                                                  input logic mirror);
    logic [PAIR_W-1:0] k;
    logic [MUX_W-1:0]  code;
    k = mirror ? ~pair : pair;
    unique case (k)
      3'd0: code = 8'h33;
      3'd1: code = 8'h00;
      3'd2: code = 8'h11;
      3'd3: code = 8'h22;
      3'd4: code = 8'h44;
      3'd5: code = 8'h66;
      3'd6: code = 8'h77;
      3'd7: code = 8'h55;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* hdl/touch_matrix_baseline_scanner_core.sv */
// ---------------------------------------------------------------------------
// touch_matrix_baseline_scanner_core
// sensor matrix scan sequencer with per-cell baseline calibration and
// baseline subtraction, two cells per sample pair
// ---------------------------------------------------------------------------
// One item is accepted every clock cycle unless a result waits unaccepted
// while the input stage is full, which stalls the input. An item passes the
// input stage, with the baseline read, and then the result register. The
// baseline lives in two 8-bit banks, one for each half of the columns, each
// with one read and one write per cycle, so both cells of a pair are read
// and updated together; a write immediately followed by a read of the same
// entry is forwarded. Per-entry valid flags are cleared at once by reset and
// by start-calibration, so there is no clearing pass and no dead time.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_matrix_baseline_scanner_core
  import tmbs_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // item channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_opcode,
  input  wire logic [SAMPLE_W-1:0] in_sample_a,
  input  wire logic [SAMPLE_W-1:0] in_sample_b,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [DRIVE_W-1:0]       out_row_drive,
  output logic [MUX_W-1:0]         out_mux_code,
  output logic [IDX_W-1:0]         out_cell_index_a,
  output logic [IDX_W-1:0]         out_cell_index_b,
  output logic [PIXEL_W-1:0]       out_pixel_a,
  output logic [PIXEL_W-1:0]       out_pixel_b,
  output logic                     out_pixels_valid,
  output logic                     out_frame_done,
  output logic                     out_calibrating,
  // register writes
  input  wire logic                cfg_we,
  input  wire logic [CFG_AW-1:0]   cfg_index,
  input  wire logic [CFG_DW-1:0]   cfg_wdata
);

  localparam int HALF_COLS  = COLUMNS / 2;
  localparam int BANK_DEPTH = ROWS * HALF_COLS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  typedef logic [BANK_AW-1:0] baddr_t;

  // configuration
  logic [PASS_W-1:0] cal_passes_r;
  logic              mirror_x_r;
  logic              mirror_y_r;

  // scan position and calibration control
  logic [ROW_W-1:0]  row_r,      row_nxt;
  logic [PAIR_W-1:0] pair_r,     pair_nxt;
  logic [PASS_W-1:0] passes_r,   passes_nxt;
  logic              cal_mode_r, cal_mode_nxt;

  // baseline banks and their valid flags
  sample_t           bank_a_mem [BANK_DEPTH];
  sample_t           bank_b_mem [BANK_DEPTH];
  logic [BANK_DEPTH-1:0] vld_r;

  // input stage
  logic              s1_valid_r;
  logic              s1_sample_r;
  logic              s1_cal_r;
  logic              s1_done_r;
  logic              s1_cal_after_r;
  sample_t           s1_va_r, s1_vb_r;
  logic [IDX_W-1:0]  s1_idx_a_r, s1_idx_b_r;
  baddr_t            s1_addr_r;
  logic [DRIVE_W-1:0] s1_drive_r;
  logic [MUX_W-1:0]  s1_mux_r;
  sample_t           rd_a_r, rd_b_r;
  logic              rd_vld_r;
  logic              byp_r;
  sample_t           byp_a_r, byp_b_r;

  // result register
  logic               out_valid_r;
  logic [DRIVE_W-1:0] out_drive_r;
  logic [MUX_W-1:0]   out_mux_r;
  logic [IDX_W-1:0]   out_idx_a_r, out_idx_b_r;
  pixel_t             out_pix_a_r, out_pix_b_r;
  logic               out_pvalid_r, out_done_r, out_cal_r;

  // accept side
  logic              in_fire, s1_adv, s1_fire, clr;
  logic [ROW_W:0]    row_inc;
  logic [PAIR_W:0]   pair_inc;
  logic              is_sample, done;
  sample_t           va, vb;
  logic [IDX_W-1:0]  idx_a, idx_b;
  baddr_t            rd_addr;
  logic [ROW_W-1:0]  drive_bit;
  logic [DRIVE_W-1:0] drive_nxt;
  logic [MUX_W-1:0]  mux_nxt;

  // result side
  sample_t           base_a, base_b, max_a, max_b;
  pixel_t            pix_a, pix_b;
  logic              wr_en;

  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign clr      = in_fire && (in_opcode == OP_START_CAL);

  // next position, mode and outputs for the accepted item
  always_comb begin
    row_inc      = {1'b0, row_r} + 5'd1;
    pair_inc     = {1'b0, pair_r} + 4'd1;
    row_nxt      = row_r;
    pair_nxt     = pair_r;
    passes_nxt   = passes_r;
    cal_mode_nxt = cal_mode_r;
    is_sample    = 1'b0;
    done         = 1'b0;
    if (in_fire) begin
      unique case (in_opcode)
        OP_START_CAL: begin
          row_nxt      = '0;
          pair_nxt     = '0;
          passes_nxt   = '0;
          cal_mode_nxt = 1'b1;
        end
        OP_START_SCAN: begin
          row_nxt      = '0;
          pair_nxt     = '0;
          cal_mode_nxt = 1'b0;
        end
        OP_SAMPLE: begin
          is_sample = 1'b1;
          if (row_inc == (ROW_W+1)'(ROWS)) begin
            row_nxt = '0;
            if (pair_inc == (PAIR_W+1)'(HALF_COLS)) begin
              pair_nxt = '0;
              done     = 1'b1;
            end else begin
              pair_nxt = pair_inc[PAIR_W-1:0];
            end
          end else begin
            row_nxt = row_inc[ROW_W-1:0];
          end
          if (done && cal_mode_r) begin
            if (passes_r != '1) begin
              passes_nxt = passes_r + 8'd1;
            end
            if (passes_nxt >= cal_passes_r) begin
              cal_mode_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    va        = mirror_x_r ? in_sample_b : in_sample_a;
    vb        = mirror_x_r ? in_sample_a : in_sample_b;
    idx_a     = IDX_W'(int'(row_r) * COLUMNS + int'(pair_r));
    idx_b     = idx_a + IDX_W'(HALF_COLS);
    rd_addr   = BANK_AW'(int'(row_r) * HALF_COLS + int'(pair_r));
    // with mirror_y the row index counts down from the top bit
    drive_bit = mirror_y_r ? ~row_nxt : row_nxt;
    drive_nxt = DRIVE_W'(1) << drive_bit;
    mux_nxt   = mux_lookup(pair_nxt, mirror_x_r);
  end

  // baseline of the current pair: forwarded write, stored entry, or zero
  always_comb begin
    if (byp_r) begin
      base_a = byp_a_r;
      base_b = byp_b_r;
    end else if (rd_vld_r) begin
      base_a = rd_a_r;
      base_b = rd_b_r;
    end else begin
      base_a = '0;
      base_b = '0;
    end
    max_a = (s1_va_r > base_a) ? s1_va_r : base_a;
    max_b = (s1_vb_r > base_b) ? s1_vb_r : base_b;
    pix_a = '0;
    pix_b = '0;
    if (s1_va_r > base_a) begin
      pix_a = ((s1_va_r - base_a) > SAMPLE_W'(PIXEL_MAX)) ? PIXEL_MAX
                                                          : PIXEL_W'(s1_va_r - base_a);
    end
    if (s1_vb_r > base_b) begin
      pix_b = ((s1_vb_r - base_b) > SAMPLE_W'(PIXEL_MAX)) ? PIXEL_MAX
                                                          : PIXEL_W'(s1_vb_r - base_b);
    end
  end

  // a start-calibration accepted in the same cycle wipes the pending update
  assign wr_en = s1_fire && s1_sample_r && s1_cal_r && !clr;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_passes_r <= PASSES_RESET;
      mirror_x_r   <= 1'b0;
      mirror_y_r   <= 1'b0;
      row_r        <= '0;
      pair_r       <= '0;
      passes_r     <= '0;
      cal_mode_r   <= 1'b0;
      vld_r        <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CAL_PASSES: cal_passes_r <= cfg_wdata;
          REG_MIRROR_X:   mirror_x_r   <= cfg_wdata[0];
          REG_MIRROR_Y:   mirror_y_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      row_r      <= row_nxt;
      pair_r     <= pair_nxt;
      passes_r   <= passes_nxt;
      cal_mode_r <= cal_mode_nxt;
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // baseline banks
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank_a_mem[s1_addr_r] <= max_a;
      bank_b_mem[s1_addr_r] <= max_b;
    end
    if (in_fire) begin
      rd_a_r <= bank_a_mem[rd_addr];
      rd_b_r <= bank_b_mem[rd_addr];
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_vld_r       <= vld_r[rd_addr];
      byp_r          <= wr_en && (s1_addr_r == rd_addr);
      byp_a_r        <= max_a;
      byp_b_r        <= max_b;
      s1_sample_r    <= is_sample;
      s1_cal_r       <= cal_mode_r;
      s1_done_r      <= done;
      s1_cal_after_r <= cal_mode_nxt;
      s1_va_r        <= va;
      s1_vb_r        <= vb;
      s1_idx_a_r     <= is_sample ? idx_a : '0;
      s1_idx_b_r     <= is_sample ? idx_b : '0;
      s1_addr_r      <= rd_addr;
      s1_drive_r     <= drive_nxt;
      s1_mux_r       <= mux_nxt;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_drive_r  <= s1_drive_r;
      out_mux_r    <= s1_mux_r;
      out_idx_a_r  <= s1_idx_a_r;
      out_idx_b_r  <= s1_idx_b_r;
      out_pvalid_r <= s1_sample_r && !s1_cal_r;
      out_pix_a_r  <= (s1_sample_r && !s1_cal_r) ? pix_a : '0;
      out_pix_b_r  <= (s1_sample_r && !s1_cal_r) ? pix_b : '0;
      out_done_r   <= s1_done_r;
      out_cal_r    <= s1_cal_after_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_drive    = out_drive_r;
  assign out_mux_code     = out_mux_r;
  assign out_cell_index_a = out_idx_a_r;
  assign out_cell_index_b = out_idx_b_r;
  assign out_pixel_a      = out_pix_a_r;
  assign out_pixel_b      = out_pix_b_r;
  assign out_pixels_valid = out_pvalid_r;
  assign out_frame_done   = out_done_r;
  assign out_calibrating  = out_cal_r;

endmodule

`default_nettype wire

/* hdl/tmbs_checker.sv */
// ---------------------------------------------------------------------------
// tmbs_checker
// port-level checks on the result stream of the matrix scanner
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tmbs_checker
  import tmbs_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [DRIVE_W-1:0]  out_row_drive,
  input wire logic [MUX_W-1:0]    out_mux_code,
  input wire logic [IDX_W-1:0]    out_cell_index_a,
  input wire logic [IDX_W-1:0]    out_cell_index_b,
  input wire logic [PIXEL_W-1:0]  out_pixel_a,
  input wire logic [PIXEL_W-1:0]  out_pixel_b,
  input wire logic                out_pixels_valid,
  input wire logic                out_frame_done,
  input wire logic                out_calibrating
);

  // a stalled word keeps its payload
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable({out_row_drive, out_mux_code, out_cell_index_a, out_cell_index_b,
    out_pixel_a, out_pixel_b, out_pixels_valid, out_frame_done, out_calibrating}),
    "result word changed while stalled")

  `ASSERT_IMPLIES(a_drive_onehot, out_valid, $onehot(out_row_drive), "row drive not one-hot")

  // a finished frame points back at the first row
  `ASSERT_IMPLIES(a_frame_wrap, out_valid && out_frame_done,
    out_row_drive == DRIVE_FIRST_UP || out_row_drive == DRIVE_FIRST_DOWN,
    "frame end without row wrap")

  // pixels only come from scan samples, never while calibrating
  `ASSERT_IMPLIES(a_pix_scan, out_valid && out_pixels_valid, !out_calibrating,
    "pixels during calibration")

  `ASSERT_IMPLIES(a_pix_zero, out_valid && !out_pixels_valid,
    out_pixel_a == '0 && out_pixel_b == '0, "nonzero pixel without valid")

endmodule

bind touch_matrix_baseline_scanner_core tmbs_checker u_tmbs_checker (.*);

`default_nettype wire

/* bench/tmbs_scan_checker.sv */
// ---------------------------------------------------------------------------
// tmbs_scan_checker
// watches the item, result and register ports of the matrix scanner, keeps
// its own copy of the scan position, calibration state and baseline, and
// compares every result word field by field with the oldest prediction
// ---------------------------------------------------------------------------
module tmbs_scan_checker
  import tmbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [SAMPLE_W-1:0] in_sample_a,
  input  logic [SAMPLE_W-1:0] in_sample_b,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [DRIVE_W-1:0]  out_row_drive,
  input  logic [MUX_W-1:0]    out_mux_code,
  input  logic [IDX_W-1:0]    out_cell_index_a,
  input  logic [IDX_W-1:0]    out_cell_index_b,
  input  logic [PIXEL_W-1:0]  out_pixel_a,
  input  logic [PIXEL_W-1:0]  out_pixel_b,
  input  logic                out_pixels_valid,
  input  logic                out_frame_done,
  input  logic                out_calibrating,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DRIVE_W-1:0] row_drive;
    logic [MUX_W-1:0]   mux_code;
    logic [IDX_W-1:0]   cell_index_a;
    logic [IDX_W-1:0]   cell_index_b;
    pixel_t             pixel_a;
    pixel_t             pixel_b;
    logic               pixels_valid;
    logic               frame_done;
    logic               calibrating;
  } scan_result_t;

  // column pair k sits at byte k; mirrored lookup reads byte 7-k
  localparam logic [63:0] MUX_TABLE = 64'h5577_6644_2211_0033;

  logic [PASS_W-1:0]   cal_passes;
  logic                flip_x;
  logic                flip_y;
  sample_t             base_mem [256];
  logic [PAIR_W-1:0]   pair_pos;
  logic [ROW_W-1:0]    row_pos;
  logic [PASS_W-1:0]   frames_taken;
  logic                calibrating_now;
  scan_result_t        scan_results_q [$];

  function automatic pixel_t above_baseline(input sample_t v, input sample_t b);
    sample_t d;
    d = v - b;
    if (v <= b) return '0;
    if (d > PIXEL_MAX) return PIXEL_MAX;
    return d[PIXEL_W-1:0];
  endfunction

  function automatic scan_result_t advance_scan(input op_t op, input sample_t sa,
                                                input sample_t sb);
    scan_result_t     r;
    sample_t          va;
    sample_t          vb;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [PAIR_W-1:0] mux_k;
    r = '0;
    case (op)
      OP_START_CAL: begin
        foreach (base_mem[i]) base_mem[i] = '0;
        frames_taken    = '0;
        pair_pos        = '0;
        row_pos         = '0;
        calibrating_now = 1'b1;
      end
      OP_START_SCAN: begin
        pair_pos        = '0;
        row_pos         = '0;
        calibrating_now = 1'b0;
      end
      OP_SAMPLE: begin
        va = flip_x ? sb : sa;
        vb = flip_x ? sa : sb;
        ia = IDX_W'(int'(row_pos) * COLUMNS_DEF + int'(pair_pos));
        ib = IDX_W'(int'(ia) + COLUMNS_DEF / 2);
        r.cell_index_a = ia;
        r.cell_index_b = ib;
        if (calibrating_now) begin
          if (va > base_mem[ia]) base_mem[ia] = va;
          if (vb > base_mem[ib]) base_mem[ib] = vb;
        end else begin
          r.pixel_a      = above_baseline(va, base_mem[ia]);
          r.pixel_b      = above_baseline(vb, base_mem[ib]);
          r.pixels_valid = 1'b1;
        end
        // row is the inner loop, column pair the outer one
        if (row_pos == ROWS_DEF - 1) begin
          row_pos = '0;
          if (pair_pos == COLUMNS_DEF / 2 - 1) begin
            pair_pos     = '0;
            r.frame_done = 1'b1;
          end else begin
            pair_pos = pair_pos + 1'b1;
          end
        end else begin
          row_pos = row_pos + 1'b1;
        end
        if (r.frame_done && calibrating_now) begin
          if (frames_taken != 8'hFF) frames_taken = frames_taken + 1'b1;
          if (frames_taken >= cal_passes) calibrating_now = 1'b0;
        end
      end
      default: ;
    endcase
    mux_k         = flip_x ? (3'd7 - pair_pos) : pair_pos;
    r.mux_code    = MUX_TABLE[8*mux_k +: 8];
    r.row_drive   = flip_y ? (DRIVE_FIRST_DOWN >> row_pos) : (DRIVE_FIRST_UP << row_pos);
    r.calibrating = calibrating_now;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      cal_passes      = PASSES_RESET;
      flip_x          = 1'b0;
      flip_y          = 1'b0;
      foreach (base_mem[i]) base_mem[i] = '0;
      pair_pos        = '0;
      row_pos         = '0;
      frames_taken    = '0;
      calibrating_now = 1'b0;
      scan_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAL_PASSES: cal_passes = cfg_wdata;
          REG_MIRROR_X:   flip_x     = cfg_wdata[0];
          REG_MIRROR_Y:   flip_y     = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        scan_results_q.push_back(advance_scan(in_opcode, in_sample_a, in_sample_b));
      if (out_valid && out_ready) begin
        if (scan_results_q.size() == 0) begin
          $error("result word with no item waiting for it");
          errors++;
        end else begin
          want = scan_results_q.pop_front();
          check_field("row_drive",    16'(want.row_drive),    16'(out_row_drive));
          check_field("mux_code",     16'(want.mux_code),     16'(out_mux_code));
          check_field("cell_index_a", 16'(want.cell_index_a), 16'(out_cell_index_a));
          check_field("cell_index_b", 16'(want.cell_index_b), 16'(out_cell_index_b));
          check_field("pixel_a",      16'(want.pixel_a),      16'(out_pixel_a));
          check_field("pixel_b",      16'(want.pixel_b),      16'(out_pixel_b));
          check_field("pixels_valid", 16'(want.pixels_valid), 16'(out_pixels_valid));
          check_field("frame_done",   16'(want.frame_done),   16'(out_frame_done));
          check_field("calibrating",  16'(want.calibrating),  16'(out_calibrating));
        end
      end
    end
    pending = scan_results_q.size();
  end

endmodule

/* bench/tb_touch_matrix_baseline_scanner_core.sv */
// ---------------------------------------------------------------------------
// tb_touch_matrix_baseline_scanner_core
// drives sample pairs, scan and calibration starts and register writes into
// the matrix scanner with random gaps on both channels; a checker beside the
// block predicts and compares every result word
// ---------------------------------------------------------------------------
module tb_touch_matrix_baseline_scanner_core
  import tmbs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam op_t      OP_UNUSED   = 2'd3;
  localparam cfg_idx_t REG_NONE    = 2'd3;
  localparam int       CELL_PAIRS  = ROWS_DEF * COLUMNS_DEF / 2;
  localparam int       STALL_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_opcode = '0;
  logic [SAMPLE_W-1:0] in_sample_a = '0;
  logic [SAMPLE_W-1:0] in_sample_b = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DRIVE_W-1:0]  out_row_drive;
  logic [MUX_W-1:0]    out_mux_code;
  logic [IDX_W-1:0]    out_cell_index_a;
  logic [IDX_W-1:0]    out_cell_index_b;
  logic [PIXEL_W-1:0]  out_pixel_a;
  logic [PIXEL_W-1:0]  out_pixel_b;
  logic                out_pixels_valid;
  logic                out_frame_done;
  logic                out_calibrating;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  int chk_errors;
  int chk_pending;
  int src_gap_pct = 16;
  int sink_stall_pct = 87;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_matrix_baseline_scanner_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_sample_a(in_sample_a), .in_sample_b(in_sample_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_drive(out_row_drive), .out_mux_code(out_mux_code),
    .out_cell_index_a(out_cell_index_a), .out_cell_index_b(out_cell_index_b),
    .out_pixel_a(out_pixel_a), .out_pixel_b(out_pixel_b),
    .out_pixels_valid(out_pixels_valid), .out_frame_done(out_frame_done),
    .out_calibrating(out_calibrating),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  tmbs_scan_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_sample_a(in_sample_a), .in_sample_b(in_sample_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_drive(out_row_drive), .out_mux_code(out_mux_code),
    .out_cell_index_a(out_cell_index_a), .out_cell_index_b(out_cell_index_b),
    .out_pixel_a(out_pixel_a), .out_pixel_b(out_pixel_b),
    .out_pixels_valid(out_pixels_valid), .out_frame_done(out_frame_done),
    .out_calibrating(out_calibrating),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(chk_errors), .pending(chk_pending)
  );

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= sink_stall_pct);

  // ends the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_touch_matrix_baseline_scanner_core: done, errors");
      $finish;
    end
  end

  function automatic sample_t rand_byte(input int unsigned hi);
    return sample_t'($urandom_range(hi));
  endfunction

  // called at a clock edge; returns at the edge where the word is taken
  task automatic offer_word(input op_t op, input sample_t a, input sample_t b);
    bit taken;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_sample_a <= a;
    in_sample_b <= b;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // wait until every result is back, then a short hold-off
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // whole frames of calibration samples with a little unused-opcode noise
  task automatic feed_frames(input int frames);
    repeat (frames * CELL_PAIRS) begin
      if ($urandom_range(99) < 3)
        offer_word(OP_UNUSED, rand_byte(255), rand_byte(255));
      offer_word(OP_SAMPLE, rand_byte(200), rand_byte(200));
    end
  endtask

  task automatic cal_then_scan(input int passes, input int scan_words);
    int pick;
    settle();
    cfg_write(REG_CAL_PASSES, CFG_DW'(passes));
    cfg_write(REG_MIRROR_X, rand_byte(255));
    cfg_write(REG_MIRROR_Y, rand_byte(255));
    if ($urandom_range(1)) cfg_write(REG_NONE, rand_byte(255));
    offer_word(OP_START_CAL, rand_byte(255), rand_byte(255));
    if (passes == 255) begin
      // lower the pass count while calibration is running
      feed_frames(1);
      settle();
      cfg_write(REG_CAL_PASSES, 8'd1);
      feed_frames(1);
    end else begin
      feed_frames(passes == 0 ? 1 : passes);
    end
    repeat (scan_words) begin
      pick = $urandom_range(99);
      if (pick < 82)
        offer_word(OP_SAMPLE, rand_byte(255), rand_byte(255));
      else if (pick < 88)
        offer_word(OP_UNUSED, rand_byte(255), rand_byte(255));
      else if (pick < 94)
        offer_word(OP_START_SCAN, rand_byte(255), rand_byte(255));
      else
        offer_word(OP_START_CAL, rand_byte(255), rand_byte(255));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scanning straight out of reset against an all-zero baseline
    offer_word(OP_SAMPLE, 8'h00, 8'hFF);
    offer_word(OP_SAMPLE, 8'hFF, 8'h00);
    offer_word(OP_UNUSED, 8'hFF, 8'hFF);
    offer_word(OP_SAMPLE, 8'h80, 8'h7F);
    offer_word(OP_START_SCAN, 8'h00, 8'h00);
    offer_word(OP_SAMPLE, 8'h01, 8'h81);
    settle();
    cfg_write(REG_MIRROR_X, 8'hFF);
    cfg_write(REG_MIRROR_Y, 8'h01);
    cfg_write(REG_NONE, 8'hA5);
    // partial calibration, abandoned by a scan start, then scan the same cells
    offer_word(OP_START_CAL, 8'hFF, 8'h00);
    repeat (4) offer_word(OP_SAMPLE, rand_byte(255), rand_byte(255));
    offer_word(OP_START_SCAN, 8'h00, 8'hFF);
    offer_word(OP_SAMPLE, 8'h00, 8'h00);
    offer_word(OP_SAMPLE, 8'hFF, 8'hFF);
    repeat (3) offer_word(OP_SAMPLE, rand_byte(255), rand_byte(255));
    offer_word(OP_START_CAL, 8'h00, 8'h00);
    offer_word(OP_START_CAL, 8'h00, 8'h00);
    offer_word(OP_SAMPLE, 8'h7F, 8'h80);
    settle();
    cfg_write(REG_MIRROR_X, 8'hFE);
    cfg_write(REG_MIRROR_Y, 8'h00);

    cal_then_scan(0, 120);
    src_gap_pct    = 87;
    sink_stall_pct = 16;
    cal_then_scan(255, 80);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    cal_then_scan(2, 80);
    cal_then_scan(1, 60);

    settle();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (chk_errors == 0 && chk_pending == 0)
      $display("tb_touch_matrix_baseline_scanner_core: done, clean");
    else
      $display("tb_touch_matrix_baseline_scanner_core: done, errors");
    $finish;
  end

endmodule
